### hdl/kmer_two_class_counter_unit_macros.svh
// Assertion macros for the k-mer two-class counter.
// Used by the top level; expects clk and arst_n in the including scope.
`ifndef KMER_TWO_CLASS_COUNTER_UNIT_MACROS_SVH
`define KMER_TWO_CLASS_COUNTER_UNIT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define KTCC_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// A condition that, once seen, must be followed by another in the next cycle.
`define KTCC_ASSERT_NEXT(label, cond, nxt, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (nxt)) \
		else $error(msg);

`endif

### hdl/ktcc_pkg.sv
// Package for the k-mer two-class counter: sizes, command codes and word types.
// No dependencies; imported by kmer_two_class_counter_unit.
package ktcc_pkg;

	localparam int KMER_LENGTH     = 10;
	localparam int COUNT_WIDTH     = 32;
	localparam int KMER_BITS       = 2 * KMER_LENGTH;
	localparam int FILL_WIDTH      = $clog2(KMER_LENGTH + 1);
	localparam int QUERY_WIDTH     = 20;
	localparam int OUT_COUNT_WIDTH = 32;
	localparam int WIDE_BITS       = (KMER_BITS > QUERY_WIDTH) ? KMER_BITS : QUERY_WIDTH;

	localparam logic [1:0] CMD_MATCH    = 2'd0;
	localparam logic [1:0] CMD_MISMATCH = 2'd1;
	localparam logic [1:0] CMD_READ     = 2'd2;

	typedef logic [KMER_BITS-1:0]   kmer_idx_t;
	typedef logic [COUNT_WIDTH-1:0] count_t;

	typedef struct packed {
		count_t match;
		count_t mismatch;
	} entry_t;

	typedef struct packed {
		logic [1:0]             cmd;
		logic [1:0]             base;
		logic                   restart;
		logic [QUERY_WIDTH-1:0] query_kmer;
	} item_t;

	typedef struct packed {
		logic                       window_full;
		logic [QUERY_WIDTH-1:0]     kmer;
		logic [OUT_COUNT_WIDTH-1:0] match_count;
		logic [OUT_COUNT_WIDTH-1:0] mismatch_count;
	} result_t;

	// What the first pipeline stage has to do with its table entry.
	typedef struct packed {
		logic upd;   // increment a counter and write the entry back
		logic mis;   // the counter to increment is the mismatch one
		logic hit;   // the result carries the entry (k-mer counted or read)
	} op_t;

	function automatic count_t sat_inc(input count_t v);
		return (v == '1) ? v : v + count_t'(1);
	endfunction

endpackage

### hdl/kmer_two_class_counter_unit.sv
// K-mer two-class counter: sliding base window and a directly indexed count table.
// Depends on ktcc_pkg and on kmer_two_class_counter_unit_macros.svh.
//
//  channel   | signals                | accepted when
//  ----------+------------------------+-------------------------------------
//  command   | start, busy, item      | rising edge with start high, busy low
//  result    | done, result           | rising edge ending the cycle of done
//
// After reset the table is cleared one entry a cycle, and busy stays high
// until every entry has been cleared. Afterwards a command word can be taken
// in every cycle. Each word is read from the table at the edge that accepts
// it, updated in the following cycle and written back at the next edge, where
// the result word and done are also registered. The single write port of the
// table sets the rate of one word per cycle. The receiver cannot stall the
// block.
module kmer_two_class_counter_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  ktcc_pkg::item_t  item,
	output logic             done,
	output ktcc_pkg::result_t result
);
	import ktcc_pkg::*;

	`include "kmer_two_class_counter_unit_macros.svh"

	// Sliding window state: newest base in the low two bits.
	kmer_idx_t             win_q;
	logic [FILL_WIDTH-1:0] fill_q;

	// Clearing pass after reset.
	logic      clearing_q;
	kmer_idx_t clr_idx_q;

	// Count table, one entry of two counters per k-mer.
	entry_t    mem [2**KMER_BITS];
	logic      mem_we;
	kmer_idx_t mem_wa;
	entry_t    mem_wd;
	kmer_idx_t rd_idx;

	// First pipeline stage: entry read back, to be updated.
	logic      valid_s1;
	op_t       op_s1;
	kmer_idx_t idx_s1;
	entry_t    rd_data_s1;

	// Copy of the last write, for the word that read the same entry at that edge.
	logic      fwd_valid_q;
	kmer_idx_t fwd_idx_q;
	entry_t    fwd_data_q;

	// Output register.
	logic    done_q;
	result_t result_q;

	logic                  accept;
	logic                  is_base;
	logic                  is_read;
	kmer_idx_t             win_base;
	logic [FILL_WIDTH-1:0] fill_base;
	kmer_idx_t             win_next;
	logic [FILL_WIDTH-1:0] fill_next;
	logic                  full_next;
	logic [WIDE_BITS-1:0]  query_wide;
	kmer_idx_t             query_idx;
	op_t                   op_in;
	entry_t                old_entry;
	entry_t                new_entry;
	logic                  upd_we;
	logic [WIDE_BITS-1:0]  idx_wide;

	assign busy   = clearing_q;
	assign accept = start && !busy;
	assign done   = done_q;
	assign result = result_q;

	// Decode the command word and work out the window as it will be after it.
	always_comb begin
		is_base = 1'b0;
		is_read = 1'b0;
		case (item.cmd)
			CMD_MATCH, CMD_MISMATCH: is_base = 1'b1;
			CMD_READ:                is_read = 1'b1;
			default:                 ;
		endcase

		// A restart empties the window before the new base goes in.
		win_base  = item.restart ? '0 : win_q;
		fill_base = item.restart ? '0 : fill_q;
		win_next  = {win_base[KMER_BITS-3:0], item.base};
		fill_next = (fill_base < FILL_WIDTH'(KMER_LENGTH)) ? fill_base + FILL_WIDTH'(1)
			: fill_base;
		full_next = (fill_next == FILL_WIDTH'(KMER_LENGTH));

		// Query bits beyond the k-mer length are dropped.
		query_wide = WIDE_BITS'(item.query_kmer);
		query_idx  = query_wide[KMER_BITS-1:0];

		op_in.upd = is_base && full_next;
		op_in.mis = (item.cmd == CMD_MISMATCH);
		op_in.hit = (is_base && full_next) || is_read;

		rd_idx = is_read ? query_idx : win_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q  <= '0;
			fill_q <= '0;
		end else if (accept && is_base) begin
			win_q  <= win_next;
			fill_q <= fill_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clearing_q) begin
			clr_idx_q <= clr_idx_q + KMER_BITS'(1);
			if (clr_idx_q == '1) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// The table is read every cycle; only the read at an accepting edge is used.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_data_s1 <= mem[rd_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			op_s1    <= '0;
		end else begin
			valid_s1 <= accept;
			op_s1    <= op_in;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx;
	end

	// Read-modify-write. The read at the accepting edge misses a write made at
	// that same edge, so such a write is taken from the forwarding register.
	always_comb begin
		old_entry = (fwd_valid_q && (fwd_idx_q == idx_s1)) ? fwd_data_q : rd_data_s1;
		new_entry = old_entry;
		if (op_s1.upd) begin
			if (op_s1.mis) begin
				new_entry.mismatch = sat_inc(old_entry.mismatch);
			end else begin
				new_entry.match = sat_inc(old_entry.match);
			end
		end
		upd_we = valid_s1 && op_s1.upd;

		mem_we = clearing_q || upd_we;
		mem_wa = clearing_q ? clr_idx_q : idx_s1;
		mem_wd = clearing_q ? '0 : new_entry;

		idx_wide = WIDE_BITS'(idx_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else begin
			fwd_valid_q <= upd_we;
		end
	end

	always_ff @(posedge clk) begin
		fwd_idx_q  <= idx_s1;
		fwd_data_q <= new_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	// A base that leaves the window short, or an unused command, gives a word
	// of zeros.
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			if (op_s1.hit) begin
				result_q.window_full    <= 1'b1;
				result_q.kmer           <= idx_wide[QUERY_WIDTH-1:0];
				result_q.match_count    <= OUT_COUNT_WIDTH'(new_entry.match);
				result_q.mismatch_count <= OUT_COUNT_WIDTH'(new_entry.mismatch);
			end else begin
				result_q <= '0;
			end
		end
	end

	// Every accepted word reaches the update stage, and then the output.
	`KTCC_ASSERT_NEXT(a_accept_to_s1, accept, valid_s1, "accepted word lost before update")
	`KTCC_ASSERT_NEXT(a_s1_to_done, valid_s1, done, "updated word produced no result")
	// Nothing is in flight while the table is being cleared.
	`KTCC_ASSERT_ALWAYS(a_clear_quiet, !clearing_q || (!valid_s1 && !upd_we),
		"table access during clearing pass")
	// A result without a k-mer carries no counts.
	`KTCC_ASSERT_ALWAYS(a_empty_result, !done || result.window_full ||
		(result.match_count == '0 && result.mismatch_count == '0 && result.kmer == '0),
		"counts reported without a full window")

endmodule
